>>> src/sma_pkg.sv
`default_nettype none

package sma_pkg;

    localparam int MAG_W  = 16;
    localparam int FRAC_W = 5;
    localparam int INT_W  = 32;
    localparam int CMD_W  = 2;

    localparam int QUO_W  = MAG_W + FRAC_W;
    localparam int ADD_W  = MAG_W + 2;
    localparam int PROD_W = 2 * MAG_W;

    localparam int DIV_STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES = (QUO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MUL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DIV = 2'd2;

    typedef struct packed {
        logic [QUO_W-1:0] dvd;
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] dvs;
        logic             div_op;
        logic             div_zero;
        logic             r_sign;
        logic [INT_W-1:0] r_int;
    } sma_work_t;

endpackage

`default_nettype wire

>>> src/sma_entry.sv
`default_nettype none

module sma_entry (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic [sma_pkg::CMD_W-1:0] cmd,
    input  wire logic                     a_sign,
    input  wire logic [sma_pkg::MAG_W-1:0] a_mag,
    input  wire logic                     b_sign,
    input  wire logic [sma_pkg::MAG_W-1:0] b_mag,
    output logic                          out_valid,
    output sma_pkg::sma_work_t            out_data
);

    sma_pkg::sma_work_t data_reg, data_next;
    logic               valid_reg;

    logic [sma_pkg::ADD_W-1:0]  a_ext, b_ext, va, vb, sum, sum_abs;
    logic [sma_pkg::PROD_W-1:0] prod;

    always_comb begin
        a_ext   = sma_pkg::ADD_W'(a_mag);
        b_ext   = sma_pkg::ADD_W'(b_mag);
        va      = a_sign ? (~a_ext + 1'b1) : a_ext;
        vb      = b_sign ? (~b_ext + 1'b1) : b_ext;
        sum     = va + vb;
        sum_abs = sum[sma_pkg::ADD_W-1] ? (~sum + 1'b1) : sum;
        prod    = sma_pkg::PROD_W'(a_mag) * sma_pkg::PROD_W'(b_mag);
    end

    always_comb begin
        data_next = '0;
        case (cmd)
            sma_pkg::CMD_ADD: begin
                data_next.r_sign = sum[sma_pkg::ADD_W-1];
                data_next.r_int  = sma_pkg::INT_W'(sum_abs);
            end
            sma_pkg::CMD_MUL: begin
                data_next.r_sign = a_sign ^ b_sign;
                data_next.r_int  = sma_pkg::INT_W'(prod);
            end
            sma_pkg::CMD_DIV: begin
                if (b_mag == '0) begin
                    data_next.div_zero = 1'b1;
                end else begin
                    data_next.div_op = 1'b1;
                    data_next.r_sign = a_sign ^ b_sign;
                    data_next.dvd    = {a_mag, {sma_pkg::FRAC_W{1'b0}}};
                    data_next.dvs    = b_mag;
                end
            end
            default: begin
                data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> src/sma_div_stage.sv
`default_nettype none

module sma_div_stage #(
    parameter int STEPS = sma_pkg::DIV_STEPS_PER_STAGE
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sma_pkg::sma_work_t in_data,
    output logic                    out_valid,
    output sma_pkg::sma_work_t      out_data
);

    sma_pkg::sma_work_t data_reg, data_next;
    logic               valid_reg;

    // Each step brings down one dividend bit and subtracts the divisor when it fits.
    always_comb begin
        logic [sma_pkg::MAG_W:0] trial;
        logic                    fits;
        data_next = in_data;
        for (int i = 0; i < STEPS; i++) begin
            trial = {data_next.rem, data_next.dvd[sma_pkg::QUO_W-1]};
            fits  = (trial >= {1'b0, data_next.dvs});
            if (fits) begin
                trial = trial - {1'b0, data_next.dvs};
            end
            data_next.rem = trial[sma_pkg::MAG_W-1:0];
            data_next.dvd = {data_next.dvd[sma_pkg::QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> src/sign_magnitude_alu_top.sv
// Sign-magnitude ALU: add, multiply and divide of two 16-bit sign-magnitude
// operands, one transaction accepted per cycle unless a stalled output holds
// the pipeline. The depth is set by the restoring divider, which resolves 21
// quotient bits (16 integer and five fraction) at three bits per pipeline
// stage over seven stages, after one entry stage that also computes the sum
// and the product. All operations travel the same pipeline so results leave
// in order. A stalled output holds the whole pipeline; nothing is dropped or
// repeated. Divide by zero returns zero with div_zero set.
`default_nettype none

module sign_magnitude_alu_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [sma_pkg::CMD_W-1:0] s_cmd,
    input  wire logic                      s_a_sign,
    input  wire logic [sma_pkg::MAG_W-1:0] s_a_mag,
    input  wire logic                      s_b_sign,
    input  wire logic [sma_pkg::MAG_W-1:0] s_b_mag,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_r_sign,
    output logic [sma_pkg::INT_W-1:0]      m_r_int,
    output logic [sma_pkg::FRAC_W-1:0]     m_r_frac,
    output logic                           m_div_zero
);

    localparam int NS  = sma_pkg::DIV_STAGES;
    localparam int SPS = sma_pkg::DIV_STEPS_PER_STAGE;

    logic                en;
    logic [NS:0]         stage_valid;
    sma_pkg::sma_work_t  stage_data [NS+1];
    sma_pkg::sma_work_t  last;
    logic                valid_reg;
    logic                sign_reg, sign_next;
    logic                dz_reg, dz_next;
    logic [sma_pkg::INT_W-1:0]  int_reg, int_next;
    logic [sma_pkg::FRAC_W-1:0] frac_reg, frac_next;

    assign en      = !valid_reg || m_ready;
    assign s_ready = en;

    sma_entry u_entry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .cmd       (s_cmd),
        .a_sign    (s_a_sign),
        .a_mag     (s_a_mag),
        .b_sign    (s_b_sign),
        .b_mag     (s_b_mag),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_div
        localparam int LEFT  = sma_pkg::QUO_W - g * SPS;
        localparam int STEPS = (LEFT < SPS) ? LEFT : SPS;

        sma_div_stage #(
            .STEPS (STEPS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stage_valid[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    assign last = stage_data[NS];

    always_comb begin
        sign_next = last.r_sign;
        dz_next   = last.div_zero;
        if (last.div_op) begin
            int_next  = sma_pkg::INT_W'(last.dvd[sma_pkg::QUO_W-1:sma_pkg::FRAC_W]);
            frac_next = last.dvd[sma_pkg::FRAC_W-1:0];
        end else begin
            int_next  = last.r_int;
            frac_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_valid[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sign_reg <= sign_next;
            dz_reg   <= dz_next;
            int_reg  <= int_next;
            frac_reg <= frac_next;
        end
    end

    assign m_valid    = valid_reg;
    assign m_r_sign   = sign_reg;
    assign m_r_int    = int_reg;
    assign m_r_frac   = frac_reg;
    assign m_div_zero = dz_reg;

endmodule

`default_nettype wire
